@@ rtl/core/lfcc_pkg.sv @@
package lfcc_pkg;

  // Frame header layout, byte offsets from the start of the frame.
  localparam int HEADER_BYTES = 32;
  localparam int COMMIT_FIRST = 8;
  localparam int SALT_FIRST   = 16;
  localparam int STORED_FIRST = 24;
  localparam int STORED_LEN   = 4;

  // The position counter saturates at HEADER_BYTES, so it must hold that value.
  localparam int POS_W = $clog2(HEADER_BYTES + 1);

  // Reflected CRC32C polynomial.
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic [31:0] previous_checksum;
    logic        frame_end;
  } item_t;

  typedef struct packed {
    logic [31:0] computed_checksum;
    logic [31:0] stored_checksum;
    status_t     status;
    logic [63:0] page_number;
    logic [63:0] size_after_commit;
    logic [31:0] first_salt;
    logic [31:0] second_salt;
  } result_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // One byte through the reflected CRC, one bit per step.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Column i is the effect of a single set bit i after 32 zero-input steps.
  function automatic crc_mat_t seed_matrix();
    crc_mat_t    m;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'b1 << i;
      for (int k = 0; k < 32; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      m[i] = c;
    end
    return m;
  endfunction

  localparam crc_mat_t SEED_MAT = seed_matrix();

  // CRC register after the four chain bytes, little endian, from all ones.
  // Hashing a 32-bit word is the same as folding it into the register and
  // running 32 zero-input steps, which is a fixed linear map.
  function automatic logic [31:0] crc_seed(logic [31:0] prev);
    logic [31:0] x;
    logic [31:0] acc;
    x   = ~prev;
    acc = 32'b0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        acc = acc ^ SEED_MAT[i];
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/core/log_frame_chained_crc32c.sv @@
// Result path: last frame byte, input register, frame stage, result register.
// Throughput: one byte per cycle if no result stalls, set by the byte-wide CRC32C update.
// A byte may be accepted while a finished result still waits on the result channel.
// Reset (rst, synchronous, active high) empties both pipeline registers and sets the CRC
// register to all ones, with position and all captured header fields cleared to zero.
module log_frame_chained_crc32c (
  input  logic              clk,
  input  logic              rst,
  input  lfcc_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_ready,
  output lfcc_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);
  import lfcc_pkg::*;

  // Input register: holds one accepted byte transaction until the frame
  // stage can process it.
  logic    s1_valid;
  item_t   s1_item;

  // The frame stage moves whenever the result register is empty or is being
  // emptied in this cycle. A byte that ends no frame still has to wait here
  // while a result is stalled, because its state update must follow the
  // frame that produced that result.
  logic    advance;
  logic    step;
  result_t frame_result;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;
  assign step       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Frame stage: chained CRC update, header capture and status, all in the
  // short path from the input register to the result register.
  lfcc_frame_state u_frame_state (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (frame_result)
  );

  // Result register: only a byte marked as the end of a frame yields a
  // result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && s1_item.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_item.frame_end) begin
      result <= frame_result;
    end
  end

endmodule

@@ rtl/core/lfcc_frame_state.sv @@
module lfcc_frame_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lfcc_pkg::item_t  item,
  output lfcc_pkg::result_t result
);
  import lfcc_pkg::*;

  logic [31:0]      crc_register;
  logic [POS_W-1:0] byte_position;
  logic [31:0]      stored_value;
  logic [63:0]      page_number_reg;
  logic [63:0]      commit_size_reg;
  logic [63:0]      salt_pair_reg;

  logic [31:0]      crc_register_next;
  logic [POS_W-1:0] byte_position_next;
  logic [31:0]      stored_value_next;
  logic [63:0]      page_number_reg_next;
  logic [63:0]      commit_size_reg_next;
  logic [63:0]      salt_pair_reg_next;

  logic [31:0]      base_crc;
  logic [POS_W-1:0] base_pos;
  logic [7:0]       hashed;
  logic [1:0]       stored_idx;
  logic [2:0]       lane;
  logic [31:0]      computed;

  always_comb begin
    // A frame start reseeds the CRC with the chain value and clears the
    // header fields before the byte itself is taken.
    if (item.frame_start) begin
      base_crc             = crc_seed(item.previous_checksum);
      base_pos             = '0;
      stored_value_next    = '0;
      page_number_reg_next = '0;
      commit_size_reg_next = '0;
      salt_pair_reg_next   = '0;
    end else begin
      base_crc             = crc_register;
      base_pos             = byte_position;
      stored_value_next    = stored_value;
      page_number_reg_next = page_number_reg;
      commit_size_reg_next = commit_size_reg;
      salt_pair_reg_next   = salt_pair_reg;
    end

    hashed             = item.data_byte;
    byte_position_next = base_pos;
    lane               = base_pos[2:0];
    stored_idx         = 2'(base_pos - POS_W'(STORED_FIRST));

    if (base_pos < POS_W'(HEADER_BYTES)) begin
      byte_position_next = base_pos + POS_W'(1);
      priority if (base_pos < POS_W'(COMMIT_FIRST)) begin
        page_number_reg_next[{lane, 3'b000} +: 8] =
          page_number_reg_next[{lane, 3'b000} +: 8] | item.data_byte;
      end else if (base_pos < POS_W'(SALT_FIRST)) begin
        commit_size_reg_next[{lane, 3'b000} +: 8] =
          commit_size_reg_next[{lane, 3'b000} +: 8] | item.data_byte;
      end else if (base_pos < POS_W'(STORED_FIRST)) begin
        salt_pair_reg_next[{lane, 3'b000} +: 8] =
          salt_pair_reg_next[{lane, 3'b000} +: 8] | item.data_byte;
      end else if (base_pos < POS_W'(STORED_FIRST + STORED_LEN)) begin
        // The stored checksum is captured and hashed as zero.
        stored_value_next[{stored_idx, 3'b000} +: 8] =
          stored_value_next[{stored_idx, 3'b000} +: 8] | item.data_byte;
        hashed = 8'h00;
      end else begin
        // Extra header bytes are hashed as received and not kept.
        hashed = item.data_byte;
      end
    end

    crc_register_next = crc_byte(base_crc, hashed);
    computed          = ~crc_register_next;

    result.computed_checksum = computed;
    result.stored_checksum   = stored_value_next;
    result.page_number       = page_number_reg_next;
    result.size_after_commit = commit_size_reg_next;
    result.first_salt        = salt_pair_reg_next[31:0];
    result.second_salt       = salt_pair_reg_next[63:32];
    priority if (byte_position_next < POS_W'(HEADER_BYTES)) begin
      result.status = STATUS_SHORT;
    end else if (computed != stored_value_next) begin
      result.status = STATUS_MISMATCH;
    end else begin
      result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register    <= '1;
      byte_position   <= '0;
      stored_value    <= '0;
      page_number_reg <= '0;
      commit_size_reg <= '0;
      salt_pair_reg   <= '0;
    end else if (step) begin
      crc_register    <= crc_register_next;
      byte_position   <= byte_position_next;
      stored_value    <= stored_value_next;
      page_number_reg <= page_number_reg_next;
      commit_size_reg <= commit_size_reg_next;
      salt_pair_reg   <= salt_pair_reg_next;
    end
  end

endmodule

@@ rtl/core/lfcc_checker.sv @@
module lfcc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input lfcc_pkg::result_t result,
  input logic              result_valid,
  input logic              result_ready
);
  import lfcc_pkg::*;

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result))
    else $error("result payload changed while stalled");

  // An ok status means the two checksums agree.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_OK) |->
      (result.computed_checksum == result.stored_checksum))
    else $error("ok status with differing checksums");

  // A mismatch status means the two checksums differ.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_MISMATCH) |->
      (result.computed_checksum != result.stored_checksum))
    else $error("mismatch status with equal checksums");

  // Reset empties the result register and leaves the input side open.
  assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("pipeline not empty after reset");

endmodule

bind log_frame_chained_crc32c lfcc_checker u_lfcc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result       (result),
  .result_valid (result_valid),
  .result_ready (result_ready)
);
